[design/lmtc_pkg.sv]
// Shared types and constants for the LCD mode and scanline timer.
package lmtc_pkg;

    localparam int DOT_W = 12;

    localparam logic [DOT_W-1:0] LINE_UNITS  = 12'd456;
    localparam logic [DOT_W-1:0] LINE_UNITS2 = 12'd912;
    localparam logic [DOT_W-1:0] OAM_BOUND   = 12'd376;
    localparam logic [DOT_W-1:0] XFER_BOUND  = 12'd204;
    localparam logic [7:0]       VBLANK_LINE = 8'd144;
    localparam logic [7:0]       LAST_LINE   = 8'd153;

    // LCD modes
    localparam logic [1:0] MODE_HBLANK = 2'd0;
    localparam logic [1:0] MODE_VBLANK = 2'd1;
    localparam logic [1:0] MODE_OAM    = 2'd2;
    localparam logic [1:0] MODE_XFER   = 2'd3;

    // Configuration register indexes
    localparam logic CFG_STAT_IRQ_EN  = 1'b0;
    localparam logic CFG_DOUBLE_SPEED = 1'b1;

    // Bits of the status interrupt enable register
    localparam int EN_HBLANK = 0;
    localparam int EN_VBLANK = 1;
    localparam int EN_OAM    = 2;
    localparam int EN_MATCH  = 3;

    typedef struct packed {
        logic [1:0] mode;
        logic [7:0] current_line;
        logic       coincidence;
        logic       stat_irq;
        logic       vblank_irq;
        logic       draw_request;
        logic [7:0] draw_line;
        logic       hdma_request;
        logic       frame_done;
    } lmtc_result_t;

endpackage

[design/lmtc_core.sv]
// Timing state, configuration registers and the per-item step logic.
module lmtc_core
    import lmtc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         step,
    input  logic [7:0]   elapsed_cycles,
    input  logic         lcd_enable,
    input  logic [7:0]   compare_line,
    input  logic         cfg_wr,
    input  logic         cfg_index,
    input  logic [3:0]   cfg_data,
    output lmtc_result_t result
);

    logic [3:0]       irq_en_reg;
    logic             dspeed_reg;
    logic [DOT_W-1:0] dot_reg, dot_next;
    logic [7:0]       line_reg, line_next;
    logic [1:0]       mode_reg, mode_next;
    logic             match_reg, match_next;

    logic             irq_en;
    logic             changed;
    logic [DOT_W:0]   dot_sub;
    logic [DOT_W-1:0] dot_red;
    logic             wrap;

    always_comb
    begin
        result     = '0;
        dot_next   = LINE_UNITS;
        line_next  = '0;
        mode_next  = MODE_HBLANK;
        match_next = match_reg;
        irq_en     = 1'b0;
        changed    = 1'b0;
        dot_sub    = '0;
        dot_red    = '0;
        wrap       = 1'b0;

        if (lcd_enable)
        begin
            // mode is taken from the state held before the step
            if (line_reg >= VBLANK_LINE)
            begin
                mode_next = MODE_VBLANK;
                irq_en    = irq_en_reg[EN_VBLANK];
            end
            else if ($signed(dot_reg) >= $signed(OAM_BOUND))
            begin
                mode_next = MODE_OAM;
                irq_en    = irq_en_reg[EN_OAM];
            end
            else if ($signed(dot_reg) >= $signed(XFER_BOUND))
            begin
                mode_next = MODE_XFER;
            end
            else
            begin
                mode_next = MODE_HBLANK;
                irq_en    = irq_en_reg[EN_HBLANK];
            end
            changed = (mode_next != mode_reg);

            match_next = (line_reg == compare_line);

            dot_sub   = {dot_reg[DOT_W-1], dot_reg} - {5'd0, elapsed_cycles};
            dot_red   = dot_sub[DOT_W-1:0];
            line_next = line_reg;
            dot_next  = dot_red;
            // zero or below starts a new line
            if (dot_sub[DOT_W] || (dot_sub == '0))
            begin
                wrap      = (line_reg == LAST_LINE);
                line_next = wrap ? 8'd0 : line_reg + 8'd1;
                dot_next  = dot_red + (dspeed_reg ? LINE_UNITS2 : LINE_UNITS);
                result.vblank_irq = (line_next == VBLANK_LINE);
            end

            result.mode         = mode_next;
            result.current_line = line_next;
            result.stat_irq     = (changed && irq_en) || (match_next && irq_en_reg[EN_MATCH]);
            result.draw_request = changed && (mode_next == MODE_XFER);
            result.draw_line    = result.draw_request ? line_reg : 8'd0;
            result.hdma_request = changed && (mode_next == MODE_HBLANK);
            result.frame_done   = wrap;
        end
        result.coincidence = match_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            irq_en_reg <= '0;
            dspeed_reg <= 1'b0;
            dot_reg    <= LINE_UNITS;
            line_reg   <= '0;
            mode_reg   <= MODE_HBLANK;
            match_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                unique case (cfg_index)
                    CFG_STAT_IRQ_EN:  irq_en_reg <= cfg_data;
                    CFG_DOUBLE_SPEED: dspeed_reg <= cfg_data[0];
                    default:          ;
                endcase
            end
            if (step)
            begin
                dot_reg   <= dot_next;
                line_reg  <= line_next;
                mode_reg  <= mode_next;
                match_reg <= match_next;
            end
        end
    end

endmodule

[design/lmtc_out_buf.sv]
// Result register with a skid stage so the input side keeps moving on a stall.
module lmtc_out_buf
    import lmtc_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  lmtc_result_t push_data,
    output logic         space,
    output logic         out_valid,
    input  logic         out_ready,
    output lmtc_result_t out_data
);

    logic         main_valid_reg, skid_valid_reg;
    lmtc_result_t main_reg, skid_reg;
    logic         pop;

    assign pop       = main_valid_reg && out_ready;
    assign space     = !skid_valid_reg;
    assign out_valid = main_valid_reg;
    assign out_data  = main_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            if (skid_valid_reg)
            begin
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                main_valid_reg <= push;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_valid_reg <= 1'b1;
            end
            else
            begin
                skid_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            if (skid_valid_reg)
            begin
                main_reg <= skid_reg;
            end
            else if (push)
            begin
                main_reg <= push_data;
            end
        end
        else if (push)
        begin
            if (!main_valid_reg)
            begin
                main_reg <= push_data;
            end
            else
            begin
                skid_reg <= push_data;
            end
        end
    end

endmodule

[design/lcd_mode_timing_controller_top.sv]
// Top level of the LCD mode and scanline timer.
//
// Input channel (in_valid/in_ready): one item per step carries the elapsed
// CPU time, the LCD enable bit and the line-compare value. Each item gives
// exactly one result item on the output channel (out_valid/out_ready): mode,
// current line, coincidence flag and the interrupt/request pulses.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data) writes the
// status interrupt enables (index 0) or the double-speed bit (index 1); it is
// always ready and should only be used while the block is idle.
// A result is registered, in the skid register if the result register is full.
// Throughput: one item per cycle while in_ready is high; the step logic sits
// between the timing state registers and a result register.
// A two-deep result buffer (register plus skid) absorbs stalls: in_ready
// drops only once two results are waiting for the receiver.
// Reset: counter 456, line 0, mode 0, flag clear, enables and double speed
// clear, result buffer empty.
module lcd_mode_timing_controller_top
    import lmtc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [7:0] elapsed_cycles,
    input  logic       lcd_enable,
    input  logic [7:0] compare_line,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] mode,
    output logic [7:0] current_line,
    output logic       coincidence,
    output logic       stat_irq,
    output logic       vblank_irq,
    output logic       draw_request,
    output logic [7:0] draw_line,
    output logic       hdma_request,
    output logic       frame_done,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_index,
    input  logic [3:0] cfg_data
);

    logic         step;
    lmtc_result_t step_result;
    lmtc_result_t out_data;

    assign cfg_ready = 1'b1;
    assign step      = in_valid && in_ready;

    lmtc_core u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .step           (step),
        .elapsed_cycles (elapsed_cycles),
        .lcd_enable     (lcd_enable),
        .compare_line   (compare_line),
        .cfg_wr         (cfg_valid && cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .result         (step_result)
    );

    lmtc_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .push_data (step_result),
        .space     (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    assign mode         = out_data.mode;
    assign current_line = out_data.current_line;
    assign coincidence  = out_data.coincidence;
    assign stat_irq     = out_data.stat_irq;
    assign vblank_irq   = out_data.vblank_irq;
    assign draw_request = out_data.draw_request;
    assign draw_line    = out_data.draw_line;
    assign hdma_request = out_data.hdma_request;
    assign frame_done   = out_data.frame_done;

endmodule
